@@ hw/rtl/rpd_pkg.sv @@
// ---------------------------------------------------------------------------
// rpd_pkg: shared types and codes of the run-length picture decoder
// Input op codes, result kinds, queue word format and decoder phases.
// ---------------------------------------------------------------------------
package rpd_pkg;

  // Field widths of the two channels
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int LEN_W     = 8;
  localparam int OFS_OUT_W = 14;

  // Input op codes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_EOS   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd2;

  // Record fields of a count byte
  localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7F;
  localparam logic [LEN_W-1:0]  COUNT_MAX  = 8'd128;
  localparam logic [1:0]        HEADER_LEN = 2'd2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command classes carried through the queue
  typedef enum logic [1:0] {
    CMD_START,
    CMD_BYTE,
    CMD_EOS
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [BYTE_W-1:0]   data;
  } cmd_t;

  // Decoder phases
  typedef enum logic [2:0] {
    PH_DONE,
    PH_HEADER,
    PH_COUNT,
    PH_REPEAT,
    PH_LITERAL
  } phase_t;

endpackage

@@ hw/rtl/rpd_front.sv @@
// ---------------------------------------------------------------------------
// rpd_front: input classifier
// Accepts input words, turns the op code into a queue command and drops
// the unused op code.
// ---------------------------------------------------------------------------
module rpd_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rpd_pkg::OP_W-1:0]  in_op,
  input  logic [rpd_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                      q_full,
  output logic                      q_push,
  output rpd_pkg::cmd_t             q_cmd
);
  import rpd_pkg::*;

  logic cmd_known;

  // Take a word whenever the queue has room
  assign in_ready = !q_full;

  // Classify the op code
  always_comb begin
    cmd_known  = 1'b1;
    q_cmd.op   = CMD_BYTE;
    q_cmd.data = in_byte_value;
    case (in_op)
      OP_START: q_cmd.op = CMD_START;
      OP_BYTE:  q_cmd.op = CMD_BYTE;
      OP_EOS:   q_cmd.op = CMD_EOS;
      default:  cmd_known = 1'b0;
    endcase
  end

  // Push known commands only, drop the rest
  assign q_push = in_valid && in_ready && cmd_known;

endmodule

@@ hw/rtl/rpd_fifo.sv @@
// ---------------------------------------------------------------------------
// rpd_fifo: command queue
// Short register queue that decouples the classifier from the decoder.
// ---------------------------------------------------------------------------
module rpd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output rpd_pkg::cmd_t head_cmd
);
  import rpd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("queue pop while empty");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

@@ hw/rtl/rpd_back.sv @@
// ---------------------------------------------------------------------------
// rpd_back: record decoder
// Walks the header, count and record phases, tracks the write offset,
// clips runs at the picture's end and holds the result in an output register.
// ---------------------------------------------------------------------------
module rpd_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  rpd_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rpd_pkg::KIND_W-1:0]    out_kind,
  output logic [rpd_pkg::BYTE_W-1:0]    out_value,
  output logic [rpd_pkg::LEN_W-1:0]     out_run_length,
  output logic [rpd_pkg::OFS_OUT_W-1:0] out_start_offset
);
  import rpd_pkg::*;

  localparam int TOTAL = COLUMNS * ROWS;
  localparam int OFS_W = $clog2(TOTAL + 1);
  localparam int SUM_W = ((OFS_W > LEN_W) ? OFS_W : LEN_W) + 1;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         skip_r, skip_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [OFS_W-1:0]   ofs_r, ofs_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [BYTE_W-1:0]    value_r, value_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [OFS_OUT_W-1:0] start_r, start_nxt;
  logic                 emit;

  logic [OFS_W-1:0]  remain;
  logic [SUM_W-1:0]  cnt_ext, rem_ext, rep_len_ext;
  logic              rep_end, lit_end;
  logic [LEN_W-1:0]  new_count;
  logic [31:0]       ofs_wide;
  logic [OFS_OUT_W-1:0] ofs_out;

  // Take a command when the output register is free or being emptied
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // Clip a repeat run at the picture's end
  assign remain      = OFS_W'(TOTAL) - ofs_r;
  assign cnt_ext     = SUM_W'(count_r);
  assign rem_ext     = SUM_W'(remain);
  assign rep_len_ext = (cnt_ext > rem_ext) ? rem_ext : cnt_ext;
  assign rep_end     = (rep_len_ext == rem_ext);
  assign lit_end     = (remain == OFS_W'(1));

  assign new_count = ((q_cmd.data & COUNT_MASK) == '0) ? COUNT_MAX
                                                        : (q_cmd.data & COUNT_MASK);
  assign ofs_wide  = 32'(ofs_r);
  assign ofs_out   = ofs_wide[OFS_OUT_W-1:0];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      case (q_cmd.op)
        CMD_START: phase_nxt = PH_HEADER;
        CMD_EOS:   phase_nxt = PH_DONE;
        CMD_BYTE: begin
          case (phase_r)
            PH_HEADER:  phase_nxt = (skip_r <= 2'd1) ? PH_COUNT : PH_HEADER;
            PH_COUNT:   phase_nxt = q_cmd.data[BYTE_W-1] ? PH_REPEAT : PH_LITERAL;
            PH_REPEAT:  phase_nxt = rep_end ? PH_DONE : PH_COUNT;
            PH_LITERAL: begin
              if (lit_end) begin
                phase_nxt = PH_DONE;
              end else if (count_r <= LEN_W'(1)) begin
                phase_nxt = PH_COUNT;
              end
            end
            default:    phase_nxt = PH_DONE;
          endcase
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Counters and result
  always_comb begin
    skip_nxt  = skip_r;
    count_nxt = count_r;
    ofs_nxt   = ofs_r;
    emit      = 1'b0;
    kind_nxt  = KIND_RUN;
    value_nxt = q_cmd.data;
    len_nxt   = LEN_W'(1);
    start_nxt = ofs_out;
    if (q_pop) begin
      case (q_cmd.op)
        CMD_START: begin
          skip_nxt  = HEADER_LEN;
          count_nxt = '0;
          ofs_nxt   = '0;
        end
        CMD_EOS: begin
          if (phase_r != PH_DONE) begin
            emit      = 1'b1;
            kind_nxt  = KIND_TRUNC;
            value_nxt = '0;
            len_nxt   = '0;
            skip_nxt  = '0;
            count_nxt = '0;
          end
        end
        CMD_BYTE: begin
          case (phase_r)
            PH_HEADER: begin
              if (skip_r != '0) begin
                skip_nxt = skip_r - 1'b1;
              end
            end
            PH_COUNT: count_nxt = new_count;
            PH_REPEAT: begin
              emit      = 1'b1;
              kind_nxt  = rep_end ? KIND_LAST : KIND_RUN;
              len_nxt   = rep_len_ext[LEN_W-1:0];
              ofs_nxt   = OFS_W'(SUM_W'(ofs_r) + rep_len_ext);
              count_nxt = '0;
            end
            PH_LITERAL: begin
              emit     = 1'b1;
              kind_nxt = lit_end ? KIND_LAST : KIND_RUN;
              ofs_nxt  = ofs_r + 1'b1;
              if (lit_end) begin
                count_nxt = '0;
              end else if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
            default: emit = 1'b0;
          endcase
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // Hold a result until taken, load a new one on emit
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      skip_r      <= '0;
      count_r     <= '0;
      ofs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      count_r     <= count_nxt;
      ofs_r       <= ofs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_value        = value_r;
  assign out_run_length   = len_r;
  assign out_start_offset = start_r;

  a_ofs_in_picture: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_DONE) |-> (ofs_r < OFS_W'(TOTAL)))
    else $error("write offset past picture end while decoding");

  a_literal_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LITERAL) |-> (count_r != '0))
    else $error("literal record with no bytes left");

  a_header_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (skip_r != '0))
    else $error("header phase with nothing left to skip");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> q_pop)
    else $error("result made without a command");

endmodule

@@ hw/rtl/rle_picture_run_decoder.sv @@
// ---------------------------------------------------------------------------
// rle_picture_run_decoder: run-length picture decoder, top level
// Decodes a run-length coded picture stream into runs of a column-major store.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one word per handshake, in_op selects start, stream byte or end
//           of stream, in_byte_value carries the byte.
//   out_* : one word per run, kind (run, last run, truncated), value, clipped
//           length and the run's start offset in the column-major store.
//   Words are accepted at one per clock while the queue has room; a
//   classifier feeds a two-word queue and the record decoder takes one
//   queued word per clock while its output register is free or emptying.
//   A result shows on out_valid after its word has passed the queue and the
//   output register. Count bytes, header bytes and ignored words give no result.
//   When the receiver stalls, the result is held in the output register, the
//   decoder stops, the queue takes up to two more words and then in_ready
//   falls until the held result is taken.
//   After reset the decoder waits for a start word; stream bytes and end of
//   stream words before it are dropped, and no clearing pass is needed.
// ---------------------------------------------------------------------------
module rle_picture_run_decoder #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpd_pkg::OP_W-1:0]      in_op,
  input  logic [rpd_pkg::BYTE_W-1:0]    in_byte_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rpd_pkg::KIND_W-1:0]    out_kind,
  output logic [rpd_pkg::BYTE_W-1:0]    out_value,
  output logic [rpd_pkg::LEN_W-1:0]     out_run_length,
  output logic [rpd_pkg::OFS_OUT_W-1:0] out_start_offset
);
  import rpd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // Classify input words
  rpd_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_byte_value (in_byte_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Queue between classifier and decoder
  rpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // Decode records into runs
  rpd_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_run_length   (out_run_length),
    .out_start_offset (out_start_offset)
  );

endmodule
